[design/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// Pixel color converter package
// Shared pixel type, mode codes and fixed conversion constants.
// ----------------------------------------------------------------------------
package pcc_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_RGB2YCC = 2'd0;
  localparam mode_t MODE_YCC2RGB = 2'd1;
  localparam mode_t MODE_NEGATE  = 2'd2;
  localparam mode_t MODE_GRAY    = 2'd3;

  localparam mode_t MODE_RESET = MODE_RGB2YCC;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } pix_t;

  // Conversion coefficients in thousandths.
  localparam int MILLI_Y_R  = 299;
  localparam int MILLI_Y_G  = 587;
  localparam int MILLI_Y_B  = 114;
  localparam int MILLI_CB_R = 169;
  localparam int MILLI_CB_G = 331;
  localparam int MILLI_HALF = 500;
  localparam int MILLI_CR_G = 419;
  localparam int MILLI_CR_B = 81;
  localparam int MILLI_R_CR = 1400;
  localparam int MILLI_G_CB = 343;
  localparam int MILLI_G_CR = 711;
  localparam int MILLI_B_CB = 1765;
  localparam int MILLI_DIV  = 1000;

  localparam int CHROMA_OFS = 128;
  localparam int PIX_MAX    = 255;

  // Division of the channel sum by three: (sum * 683) >> 11 is exact up to 765.
  localparam int GSUM_W      = 10;
  localparam int GRAY_RECIP  = 683;
  localparam int GRAY_SHIFT  = 11;
  localparam int GPROD_W     = 21;

endpackage

[design/pcc_in_if.sv]
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one three-channel source pixel.
// ----------------------------------------------------------------------------
interface pcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;

  modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
  modport sink   (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

[design/pcc_out_if.sv]
// ----------------------------------------------------------------------------
// Pixel result channel
// Valid/ready channel carrying one three-channel converted pixel.
// ----------------------------------------------------------------------------
interface pcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_a;
  logic [7:0] out_b;
  logic [7:0] out_c;

  modport source (output valid, output out_a, output out_b, output out_c, input ready);
  modport sink   (input valid, input out_a, input out_b, input out_c, output ready);
endinterface

[design/pcc_cfg_if.sv]
// ----------------------------------------------------------------------------
// Mode configuration channel
// Valid/ready write channel carrying the mode register value.
// ----------------------------------------------------------------------------
interface pcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;

  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

[design/pcc_mode_reg.sv]
// ----------------------------------------------------------------------------
// Mode register
// Holds the conversion mode, written by a transfer on the configuration channel.
// ----------------------------------------------------------------------------
module pcc_mode_reg (
  input  logic           clk,
  input  logic           rst_n,
  pcc_cfg_if.sink        cfg,
  output pcc_pkg::mode_t mode
);

  pcc_pkg::mode_t mode_r;
  pcc_pkg::mode_t mode_nxt;

  assign cfg.ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg.valid) begin
      mode_nxt = cfg.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pcc_pkg::MODE_RESET;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign mode = mode_r;

endmodule

[design/pcc_datapath.sv]
// ----------------------------------------------------------------------------
// Conversion datapath
// Fixed-point color conversion, inversion and gray averaging of one pixel.
// ----------------------------------------------------------------------------
module pcc_datapath #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  pcc_pkg::mode_t mode,
  input  pcc_pkg::pix_t  pix_in,
  output pcc_pkg::pix_t  pix_out
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int SW = F + 12;

  localparam logic signed [SW-1:0] K_Y_R  =
    SW'(((longint'(pcc_pkg::MILLI_Y_R) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_Y_G  =
    SW'(((longint'(pcc_pkg::MILLI_Y_G) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_Y_B  =
    SW'(((longint'(pcc_pkg::MILLI_Y_B) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_CB_R =
    SW'(((longint'(pcc_pkg::MILLI_CB_R) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_CB_G =
    SW'(((longint'(pcc_pkg::MILLI_CB_G) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_HALF =
    SW'(((longint'(pcc_pkg::MILLI_HALF) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_CR_G =
    SW'(((longint'(pcc_pkg::MILLI_CR_G) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_CR_B =
    SW'(((longint'(pcc_pkg::MILLI_CR_B) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_R_CR =
    SW'(((longint'(pcc_pkg::MILLI_R_CR) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_G_CB =
    SW'(((longint'(pcc_pkg::MILLI_G_CB) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_G_CR =
    SW'(((longint'(pcc_pkg::MILLI_G_CR) << F) + 500) / pcc_pkg::MILLI_DIV);
  localparam logic signed [SW-1:0] K_B_CB =
    SW'(((longint'(pcc_pkg::MILLI_B_CB) << F) + 500) / pcc_pkg::MILLI_DIV);

  localparam logic signed [SW-1:0] FRAC_MASK = SW'((longint'(1) << F) - 1);
  localparam logic signed [SW-1:0] OFS_ZERO  = SW'(0);
  localparam logic signed [SW-1:0] OFS_CHR   = SW'(pcc_pkg::CHROMA_OFS);
  localparam logic signed [SW-1:0] VAL_MAX   = SW'(pcc_pkg::PIX_MAX);

  logic signed [SW-1:0] sa, sb, sc, sdb, sdc, sy;
  logic signed [SW-1:0] fwd0, fwd1, fwd2, inv0, inv1, inv2;
  logic [7:0]           fwd_a, fwd_b, fwd_c, inv_a, inv_b, inv_c;
  logic [pcc_pkg::GSUM_W-1:0]  gsum;
  logic [pcc_pkg::GPROD_W-1:0] gprod;
  logic [7:0]                  gray;

  // Truncates toward zero, adds the offset and saturates to 0..255.
  function automatic logic [7:0] trunc_clamp(input logic signed [SW-1:0] s,
                                             input logic signed [SW-1:0] ofs);
    logic signed [SW-1:0] t;
    logic [7:0]           r;
    if (s[SW-1]) begin
      t = (s + FRAC_MASK) >>> F;
    end else begin
      t = s >>> F;
    end
    t = t + ofs;
    if (t[SW-1]) begin
      r = 8'd0;
    end else if (t > VAL_MAX) begin
      r = 8'hFF;
    end else begin
      r = t[7:0];
    end
    return r;
  endfunction

  always_comb begin
    sa  = SW'(signed'({1'b0, pix_in.a}));
    sb  = SW'(signed'({1'b0, pix_in.b}));
    sc  = SW'(signed'({1'b0, pix_in.c}));
    sdb = sb - OFS_CHR;
    sdc = sc - OFS_CHR;
    sy  = sa <<< F;

    fwd0 = K_Y_R * sa + K_Y_G * sb + K_Y_B * sc;
    fwd1 = K_HALF * sc - K_CB_R * sa - K_CB_G * sb;
    fwd2 = K_HALF * sa - K_CR_G * sb - K_CR_B * sc;

    inv0 = sy + K_R_CR * sdc;
    inv1 = sy - K_G_CB * sdb - K_G_CR * sdc;
    inv2 = sy + K_B_CB * sdb;

    fwd_a = trunc_clamp(fwd0, OFS_ZERO);
    fwd_b = trunc_clamp(fwd1, OFS_CHR);
    fwd_c = trunc_clamp(fwd2, OFS_CHR);
    inv_a = trunc_clamp(inv0, OFS_ZERO);
    inv_b = trunc_clamp(inv1, OFS_ZERO);
    inv_c = trunc_clamp(inv2, OFS_ZERO);

    gsum  = pcc_pkg::GSUM_W'(pix_in.a) + pcc_pkg::GSUM_W'(pix_in.b)
          + pcc_pkg::GSUM_W'(pix_in.c);
    gprod = pcc_pkg::GPROD_W'(gsum) * pcc_pkg::GPROD_W'(pcc_pkg::GRAY_RECIP);
    gray  = gprod[pcc_pkg::GRAY_SHIFT +: 8];

    unique case (mode)
      pcc_pkg::MODE_RGB2YCC: pix_out = '{a: fwd_a, b: fwd_b, c: fwd_c};
      pcc_pkg::MODE_YCC2RGB: pix_out = '{a: inv_a, b: inv_b, c: inv_c};
      pcc_pkg::MODE_NEGATE:  pix_out = '{a: ~pix_in.a, b: ~pix_in.b, c: ~pix_in.c};
      pcc_pkg::MODE_GRAY:    pix_out = '{a: gray, b: gray, c: gray};
      default:               pix_out = '{a: gray, b: gray, c: gray};
    endcase
  end

endmodule

[design/pixel_color_convert_top.sv]
// ----------------------------------------------------------------------------
// Pixel color converter
// Per-pixel RGB/YCbCr conversion, inversion and gray averaging.
// ----------------------------------------------------------------------------
// One pixel enters per cycle while the sink is ready. The pixel is captured
// in an input register at its input transfer, converted by fixed-point logic
// with COEF_FRAC_BITS fractional bits and held in a result register until
// the sink takes it. Throughput is one pixel per cycle as long as the sink
// is ready; a stalled result holds while one more pixel waits in the input
// register. The mode register applies to pixels in flight, so the user must
// write it only while no pixel is pending; the block does not enforce this.
module pixel_color_convert_top #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  pcc_in_if.sink    in_pix,
  pcc_out_if.source out_pix,
  pcc_cfg_if.sink   cfg_wr
);

  pcc_pkg::mode_t mode;

  logic          s1_valid_r, s1_valid_nxt;
  pcc_pkg::pix_t s1_pix_r, s1_pix_nxt;
  logic          out_valid_r, out_valid_nxt;
  pcc_pkg::pix_t out_pix_r, out_pix_nxt;
  pcc_pkg::pix_t conv_pix;
  logic          out_load;
  logic          in_xfer;

  pcc_mode_reg u_mode_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .mode  (mode)
  );

  pcc_datapath #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .mode    (mode),
    .pix_in  (s1_pix_r),
    .pix_out (conv_pix)
  );

  assign out_load     = s1_valid_r && (!out_valid_r || out_pix.ready);
  assign in_pix.ready = !s1_valid_r || out_load;
  assign in_xfer      = in_pix.valid && in_pix.ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_pix_nxt    = s1_pix_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
      s1_pix_nxt   = '{a: in_pix.chan_a, b: in_pix.chan_b, c: in_pix.chan_c};
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_pix_nxt   = conv_pix;
    end else if (out_pix.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r  <= s1_pix_nxt;
    out_pix_r <= out_pix_nxt;
  end

  assign out_pix.valid = out_valid_r;
  assign out_pix.out_a = out_pix_r.a;
  assign out_pix.out_b = out_pix_r.b;
  assign out_pix.out_c = out_pix_r.c;

endmodule

[verif/pixel_color_convert_top_tb.sv]
// ----------------------------------------------------------------------------
// Pixel color converter testbench
// Drives random and corner-case pixels through all four conversion modes with
// bursty input traffic and a stalling result sink. A scoreboard predicts every
// converted pixel, the color conversions in fixed point, and compares it with
// the pixel the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_color_convert_top_tb;
  import pcc_pkg::*;

  localparam int FRAC_BITS = 14;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PIXELS = 240;

  class pix_scoreboard;
    mode_t      cur_mode;
    pix_t       expected_q[$];
    int         errors;
    int         checked;
    int         mode_writes;
    int         per_mode[4];

    function new();
      cur_mode = MODE_RESET;
      errors = 0;
      checked = 0;
      mode_writes = 0;
      foreach (per_mode[i]) per_mode[i] = 0;
    endfunction

    function longint coef(input longint milli);
      return ((milli << FRAC_BITS) + 500) / 1000;
    endfunction

    function longint fx_trunc(input longint s);
      if (s < 0) begin
        return -((-s) >> FRAC_BITS);
      end
      return s >> FRAC_BITS;
    endfunction

    function logic [7:0] clamp8(input longint v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    function pix_t convert(input pix_t p);
      longint a, b, c, db, dc, y;
      pix_t   r;
      a = p.a;
      b = p.b;
      c = p.c;
      case (cur_mode)
        MODE_RGB2YCC: begin
          r.a = clamp8(fx_trunc(coef(299) * a + coef(587) * b + coef(114) * c));
          r.b = clamp8(fx_trunc(-coef(169) * a - coef(331) * b + coef(500) * c) + 128);
          r.c = clamp8(fx_trunc(coef(500) * a - coef(419) * b - coef(81) * c) + 128);
        end
        MODE_YCC2RGB: begin
          y  = a << FRAC_BITS;
          db = b - 128;
          dc = c - 128;
          r.a = clamp8(fx_trunc(y + coef(1400) * dc));
          r.b = clamp8(fx_trunc(y - coef(343) * db - coef(711) * dc));
          r.c = clamp8(fx_trunc(y + coef(1765) * db));
        end
        MODE_NEGATE: begin
          r.a = 8'd255 - p.a;
          r.b = 8'd255 - p.b;
          r.c = 8'd255 - p.c;
        end
        default: begin
          y = (a + b + c) / 3;
          r.a = y[7:0];
          r.b = y[7:0];
          r.c = y[7:0];
        end
      endcase
      return r;
    endfunction

    function void set_mode(input mode_t m);
      cur_mode = m;
      mode_writes++;
    endfunction

    function void note_input(input pix_t p);
      expected_q.push_back(convert(p));
      per_mode[cur_mode]++;
    endfunction

    function void check_result(input pix_t got);
      pix_t exp_pix;
      if (expected_q.size() == 0) begin
        $error("Result transfer with no pixel pending: %h", got);
        errors++;
        return;
      end
      exp_pix = expected_q.pop_front();
      checked++;
      if (got.a !== exp_pix.a) begin
        $error("out_a expected %0d got %0d", exp_pix.a, got.a);
        errors++;
      end
      if (got.b !== exp_pix.b) begin
        $error("out_b expected %0d got %0d", exp_pix.b, got.b);
        errors++;
      end
      if (got.c !== exp_pix.c) begin
        $error("out_c expected %0d got %0d", exp_pix.c, got.c);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pcc_in_if  in_if();
  pcc_out_if out_if();
  pcc_cfg_if cfg_if();

  pix_scoreboard sb = new();

  pixel_color_convert_top #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_if),
    .out_pix (out_if),
    .cfg_wr  (cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.set_mode(cfg_if.mode);
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_input(pix_t'({in_if.chan_a, in_if.chan_b, in_if.chan_c}));
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(pix_t'({out_if.out_a, out_if.out_b, out_if.out_c}));
      end
    end
  end

  initial begin
    int stall_pct;
    int span;
    forever begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      span = $urandom_range(8, 80);
      repeat (span) begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("pixel_color_convert_top_tb: FAIL");
    $finish;
  end

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(120, 136));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    p.a = rand_chan();
    p.b = rand_chan();
    p.c = rand_chan();
    return p;
  endfunction

  task automatic send_pixel(input pix_t p);
    in_if.valid  <= 1'b1;
    in_if.chan_a <= p.a;
    in_if.chan_b <= p.b;
    in_if.chan_c <= p.c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    repeat (4) @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.mode  <= m;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input int count, input bit gapless);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) burst = left;
      repeat (burst) send_pixel(rand_pixel());
      left -= burst;
      gap = gapless ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    pix_t  corner[6];
    mode_t order[4];
    mode_t m;

    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.chan_a = 8'd0;
    in_if.chan_b = 8'd0;
    in_if.chan_c = 8'd0;
    cfg_if.valid = 1'b0;
    cfg_if.mode  = MODE_RESET;

    corner = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'h00ffff};
    order  = '{MODE_RGB2YCC, MODE_YCC2RGB, MODE_NEGATE, MODE_GRAY};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (order[i]) begin
      write_mode(order[i]);
      foreach (corner[j]) send_pixel(corner[j]);
      in_if.valid <= 1'b0;
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 4) begin
        m = order[3 - ph];
      end else begin
        m = mode_t'($urandom_range(0, 3));
      end
      write_mode(m);
      run_phase(PHASE_PIXELS, (ph % 2) == 0);
    end

    repeat (8) @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);

    $display("Checked %0d converted pixels over %0d mode writes.", sb.checked, sb.mode_writes);
    $display("Pixels per mode: rgb2ycc %0d, ycc2rgb %0d, negate %0d, gray %0d.",
             sb.per_mode[MODE_RGB2YCC], sb.per_mode[MODE_YCC2RGB],
             sb.per_mode[MODE_NEGATE], sb.per_mode[MODE_GRAY]);
    if (sb.errors == 0) begin
      $display("pixel_color_convert_top_tb: PASS");
    end else begin
      $display("pixel_color_convert_top_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/pcc_pkg.sv
design/pcc_in_if.sv
design/pcc_out_if.sv
design/pcc_cfg_if.sv
design/pcc_mode_reg.sv
design/pcc_datapath.sv
design/pixel_color_convert_top.sv
verif/pixel_color_convert_top_tb.sv
